/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the LED blink and fade controller.
// Defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LBF_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LBF_ASSERT(lbl, clk, rst_n, expr, msg)
`define LBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/lbf_pkg.sv */
// Types, widths and codes of the LED blink and fade controller.
// Used by every module of the block; depends on nothing.
package lbf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_BITS = 16;

    localparam int CODE_W = 8;
    localparam int TIME_W = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int LVL_W  = 10 + FRAC_BITS;
    localparam int SUM_W  = LVL_W + 2;
    localparam int NUM_W  = CODE_W + TIME_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int TIMER_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [LVL_W:0] STEP_LIMIT = {1'b1, {LVL_W{1'b0}}};
    localparam logic signed [SUM_W-1:0] LVL_MAX =
        SUM_W'((64'sd1 <<< (LVL_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] LVL_MIN =
        SUM_W'(-(64'sd1 <<< (LVL_W - 1)));
    localparam logic [CODE_W-1:0] DIM_RESET    = 8'd255;
    localparam logic [CODE_W-1:0] BRIGHT_RESET = 8'd0;
    localparam logic [CODE_W-1:0] CODE_MAX     = 8'd255;

    localparam logic REG_DIM    = 1'b0;
    localparam logic REG_BRIGHT = 1'b1;

    typedef enum logic [2:0] {
        OP_STEADY     = 3'd0,
        OP_BLINK      = 3'd1,
        OP_FADE_IN    = 3'd2,
        OP_FADE_OUT   = 3'd3,
        OP_FADE_INOUT = 3'd4,
        OP_RESET      = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_BLINK  = 3'd1,
        MODE_FIN    = 3'd2,
        MODE_FOUT   = 3'd3,
        MODE_FINOUT = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        DIR_ZERO = 2'b00,
        DIR_UP   = 2'b01,
        DIR_DOWN = 2'b11
    } t_dir;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] dim;
        logic [CODE_W-1:0] bright;
    } t_cfg;

    function automatic logic signed [LVL_W-1:0] to_fixed(input logic [CODE_W-1:0] code);
        to_fixed = {{(LVL_W - CODE_W - FRAC_BITS){1'b0}}, code, {FRAC_BITS{1'b0}}};
    endfunction

endpackage

/* sv/lbf_regs.sv */
// Configuration registers of the LED blink and fade controller behind an APB port.
// Depends on lbf_pkg.
module lbf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbf_pkg::ADDR_W-1:0]   paddr,
    input  logic [lbf_pkg::DATA_W-1:0]   pwdata,
    output logic [lbf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output lbf_pkg::t_cfg                o_cfg
);
    import lbf_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim    <= DIM_RESET;
            r_cfg.bright <= BRIGHT_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_DIM:    r_cfg.dim    <= pwdata[CODE_W-1:0];
                REG_BRIGHT: r_cfg.bright <= pwdata[CODE_W-1:0];
                default:    r_cfg.dim    <= r_cfg.dim;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DIM:    prdata = DATA_W'(r_cfg.dim);
            REG_BRIGHT: prdata = DATA_W'(r_cfg.bright);
            default:    prdata = '0;
        endcase
    end

endmodule

/* sv/lbf_divider.sv */
// Serial restoring divider producing one quotient bit per cycle.
// Depends on lbf_pkg for the operand widths.
module lbf_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lbf_pkg::NUM_W-1:0]  i_num,
    input  logic [lbf_pkg::TIME_W-1:0] i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [lbf_pkg::NUM_W-1:0]  o_quot
);
    import lbf_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [NUM_W-1:0]  r_quot;
    logic [TIME_W:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quot[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= w_fit ? TIME_W'(w_trial - {1'b0, r_den}) : w_trial[TIME_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], w_fit};
        end
    end

endmodule

/* sv/led_blink_fade_controller.sv */
// Each input beat is one time tick and yields one output beat with the PWM code, a flag
// saying whether the tick drives the PWM output, and the active time in milliseconds.
// A tick that moves the level in blink or fade mode passes through the serial divider that
// works out the ramp step one quotient bit per cycle; every other tick skips the divider.
// The slave side is ready only while the block is idle, and a finished result waits in
// the output register until taken.
module led_blink_fade_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: opcode[2:0], elapsed_ms[18:3], ramp_ms[34:19], zero fill [39:35]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata,
    // tdata: pwm_level[7:0], pwm_written[8], active_time_ms[40:9], zero fill [47:41]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbf_pkg::ADDR_W-1:0]     paddr,
    input  logic [lbf_pkg::DATA_W-1:0]     pwdata,
    output logic [lbf_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import lbf_pkg::*;
    `include "assert_macros.svh"

    t_cfg w_cfg;

    t_state r_state, n_state;
    t_opcode r_op;
    logic [TIME_W-1:0] r_delta, r_ramp;
    logic r_use_div;
    t_mode r_mode, n_mode;
    t_dir r_dir, n_dir;
    logic signed [LVL_W-1:0] r_level, n_level;
    logic r_act_flag, n_act_flag;
    logic [TIMER_W-1:0] r_act_timer, n_act_timer;
    logic r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_out_level, n_out_level;
    logic r_out_written, n_out_written;

    logic w_accept, w_commit, w_div_start, w_use_div;
    logic w_div_busy, w_div_done;
    logic [NUM_W-1:0] w_quot, w_num;
    logic signed [CODE_W:0] w_diff;
    logic [CODE_W-1:0] w_mag;
    logic [CODE_W+TIME_W-1:0] w_prod;
    logic [LVL_W:0] w_qlim;
    logic signed [SUM_W-1:0] w_step, w_sum, w_sat;
    logic signed [LVL_W-1:0] w_lo, w_hi;
    logic w_neg;
    logic [9:0] w_ip;

    lbf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lbf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_ramp),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_act_timer, r_out_written, r_out_level};

    assign w_diff = $signed({1'b0, w_cfg.dim}) - $signed({1'b0, w_cfg.bright});
    assign w_mag  = w_diff[CODE_W] ? CODE_W'(-w_diff) : w_diff[CODE_W-1:0];
    assign w_prod = w_mag * r_delta;
    assign w_num  = {w_prod, {FRAC_BITS{1'b0}}};
    assign w_lo   = to_fixed(w_cfg.bright);
    assign w_hi   = to_fixed(w_cfg.dim);

    assign w_use_div = (r_op == OP_BLINK || r_op == OP_FADE_IN || r_op == OP_FADE_OUT ||
                        r_op == OP_FADE_INOUT) && (r_mode == t_mode'(r_op)) &&
                       (r_dir != DIR_ZERO) && (r_ramp != '0) && (w_mag != '0);
    assign w_div_start = (r_state == ST_MUL) && w_use_div;
    assign w_commit    = (r_state == ST_UPD) && (!r_out_valid || m_axis_tready);

    assign w_qlim = !r_use_div ? '0 :
                    (w_quot > NUM_W'(STEP_LIMIT)) ? STEP_LIMIT : w_quot[LVL_W:0];
    assign w_neg  = w_diff[CODE_W] ^ (r_dir == DIR_DOWN);
    assign w_step = w_neg ? -$signed(SUM_W'(w_qlim)) : $signed(SUM_W'(w_qlim));
    assign w_sum  = $signed({{2{r_level[LVL_W-1]}}, r_level}) + w_step;
    assign w_sat  = (w_sum > LVL_MAX) ? LVL_MAX : (w_sum < LVL_MIN) ? LVL_MIN : w_sum;

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_dir         = r_dir;
        n_level       = r_level;
        n_act_flag    = r_act_flag;
        n_act_timer   = r_act_timer;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_level   = r_out_level;
        n_out_written = r_out_written;
        w_ip          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = w_use_div ? ST_DIV : ST_UPD;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (w_commit) begin
                    n_state       = ST_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_written = 1'b0;
                    if (r_op == OP_STEADY || r_op == OP_BLINK || r_op == OP_FADE_IN ||
                        r_op == OP_FADE_OUT || r_op == OP_FADE_INOUT) begin
                        n_act_flag = 1'b1;
                        if (r_act_flag) begin
                            n_act_timer = r_act_timer + TIMER_W'(r_delta);
                        end
                    end
                    unique case (r_op)
                        OP_STEADY: begin
                            n_mode        = MODE_NONE;
                            n_dir         = DIR_ZERO;
                            n_level       = w_lo;
                            n_out_written = 1'b1;
                        end
                        OP_RESET: begin
                            n_mode        = MODE_NONE;
                            n_dir         = DIR_ZERO;
                            n_level       = w_hi;
                            n_act_flag    = 1'b0;
                            n_act_timer   = '0;
                            n_out_written = 1'b1;
                        end
                        OP_BLINK, OP_FADE_IN, OP_FADE_OUT, OP_FADE_INOUT: begin
                            n_out_written = 1'b1;
                            if (r_mode != t_mode'(r_op)) begin
                                n_mode = t_mode'(r_op);
                                if (r_op == OP_BLINK || r_op == OP_FADE_OUT) begin
                                    n_level = w_lo;
                                    n_dir   = DIR_UP;
                                end else begin
                                    n_level = w_hi;
                                    n_dir   = DIR_DOWN;
                                end
                            end else begin
                                n_level = w_sat[LVL_W-1:0];
                                priority if (r_op == OP_BLINK) begin
                                    n_out_written = 1'b0;
                                    if (w_sat <= SUM_W'(w_lo)) begin
                                        n_level       = w_lo;
                                        n_dir         = DIR_UP;
                                        n_out_written = 1'b1;
                                    end else if (w_sat >= SUM_W'(w_hi)) begin
                                        n_level       = w_hi;
                                        n_dir         = DIR_DOWN;
                                        n_out_written = 1'b1;
                                    end
                                end else if (r_op == OP_FADE_IN) begin
                                    if (w_sat < SUM_W'(w_lo)) begin
                                        n_level = w_hi;
                                    end
                                end else if (r_op == OP_FADE_OUT) begin
                                    if (w_sat > SUM_W'(w_hi)) begin
                                        n_level = w_lo;
                                    end
                                end else begin
                                    if (w_sat <= SUM_W'(w_lo)) begin
                                        n_level = w_lo;
                                        n_dir   = DIR_UP;
                                    end else if (w_sat >= SUM_W'(w_hi)) begin
                                        n_level = w_hi;
                                        n_dir   = DIR_DOWN;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_out_written = 1'b0;
                        end
                    endcase
                    w_ip = n_level[LVL_W-1:FRAC_BITS];
                    if (n_level[LVL_W-1]) begin
                        n_out_level = '0;
                    end else if (w_ip > 10'(CODE_MAX)) begin
                        n_out_level = CODE_MAX;
                    end else begin
                        n_out_level = w_ip[CODE_W-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_NONE;
            r_dir       <= DIR_ZERO;
            r_level     <= to_fixed(DIM_RESET);
            r_act_flag  <= 1'b0;
            r_act_timer <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_dir       <= n_dir;
            r_level     <= n_level;
            r_act_flag  <= n_act_flag;
            r_act_timer <= n_act_timer;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_level   <= n_out_level;
        r_out_written <= n_out_written;
        if (w_accept) begin
            r_op    <= t_opcode'(s_axis_tdata[2:0]);
            r_delta <= s_axis_tdata[3 +: TIME_W];
            r_ramp  <= s_axis_tdata[19 +: TIME_W];
        end
        if (r_state == ST_MUL) begin
            r_use_div <= w_use_div;
        end
    end

    `LBF_ASSERT(a_mode_dir, i_clk, i_rst_n, (r_mode == MODE_NONE) == (r_dir == DIR_ZERO), "direction and mode disagree")
    `LBF_ASSERT_IMPL(a_timer_flag, i_clk, i_rst_n, !r_act_flag, r_act_timer == '0, "active time counted before activation")
    `LBF_ASSERT_IMPL(a_div_state, i_clk, i_rst_n, w_div_busy, r_state == ST_DIV, "divider busy outside the divide state")
    `LBF_ASSERT_IMPL(a_out_src, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_UPD), "result raised outside the update state")

endmodule
